### src/psc_pkg.sv
// psc_pkg: shared types, widths and constants of the pressure sensor compensation pipeline
// used by psc_cfg, psc_front, psc_back and pressure_sensor_compensation; no dependencies
package psc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COEFF_W   = 16;
  localparam int RAW_W     = 24;
  localparam int OUT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SENS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

  localparam int TEMP_REF = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int COLD_DEV = TEMP_COLD - TEMP_REF;

  localparam int SH_REF    = 8;
  localparam int SH_C2     = 16;
  localparam int SH_C1     = 15;
  localparam int SH_TEMP   = 23;
  localparam int SH_OFF    = 7;
  localparam int SH_SENS   = 8;
  localparam int SH_T2_LO  = 33;
  localparam int SH_T2_HI  = 37;
  localparam int SH_P1     = 21;
  localparam int SH_P2     = 15;

  localparam int DT_W   = RAW_W + 1;
  localparam int PRD_W  = DT_W + COEFF_W + 1;
  localparam int DT2_W  = 2 * DT_W;
  localparam int DEV_W  = 18;
  localparam int SQ_W   = 2 * DEV_W - 1;
  localparam int T2_W   = 19;
  localparam int TEMP_W = 21;
  localparam int OFF_W  = 40;
  localparam int SENS_W = 39;
  localparam int SPLIT  = SENS_W / 2;
  localparam int PPL_W  = SPLIT + RAW_W;
  localparam int PPH_W  = SENS_W - SPLIT + RAW_W + 1;
  localparam int PROD_W = 64;
  localparam int Q_W    = PROD_W - SH_P1;
  localparam int R_W    = Q_W + 1;
  localparam int PRES_W = R_W - SH_P2;
  localparam int SAT_W  = 48;

  typedef struct packed {
    logic [COEFF_W-1:0] c1;
    logic [COEFF_W-1:0] c2;
    logic [COEFF_W-1:0] c3;
    logic [COEFF_W-1:0] c4;
    logic [COEFF_W-1:0] c5;
    logic [COEFF_W-1:0] c6;
  } coeff_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } mid_t;

  function automatic logic signed [OUT_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = 48'sd2147483647;
    lo = -48'sd2147483648;
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

### src/psc_cfg.sv
// psc_cfg: calibration word registers written through the configuration channel
// depends on psc_pkg
module psc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psc_pkg::COEFF_W-1:0]   cfg_data,
  output psc_pkg::coeff_t               coeff
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psc_pkg::REG_SENS:       coeff.c1 <= cfg_data;
        psc_pkg::REG_OFFSET:     coeff.c2 <= cfg_data;
        psc_pkg::REG_SENS_TC:    coeff.c3 <= cfg_data;
        psc_pkg::REG_OFFSET_TC:  coeff.c4 <= cfg_data;
        psc_pkg::REG_TEMP_REF:   coeff.c5 <= cfg_data;
        psc_pkg::REG_TEMP_SLOPE: coeff.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/psc_front.sv
// psc_front: stages one to five, first order terms, temperature and second order corrections
// depends on psc_pkg; feeds psc_back with one mid_t word per valid cycle while en is high
module psc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [psc_pkg::RAW_W-1:0] raw_pressure,
  input  logic [psc_pkg::RAW_W-1:0] raw_temperature,
  input  psc_pkg::coeff_t           coeff,
  output logic                      mid_valid,
  output psc_pkg::mid_t             mid
);

  // stage 1
  logic                              s1_valid;
  logic [psc_pkg::RAW_W-1:0]         s1_d1;
  logic signed [psc_pkg::DT_W-1:0]   s1_dt;
  logic signed [psc_pkg::DT_W:0]     dt_wide;

  // stage 2
  logic                              s2_valid;
  logic [psc_pkg::RAW_W-1:0]         s2_d1;
  logic signed [psc_pkg::PRD_W-1:0]  s2_p6;
  logic signed [psc_pkg::PRD_W-1:0]  s2_p4;
  logic signed [psc_pkg::PRD_W-1:0]  s2_p3;
  logic signed [psc_pkg::DT2_W-1:0]  s2_dt2;
  logic signed [psc_pkg::PRD_W-1:0]  p6_next;
  logic signed [psc_pkg::PRD_W-1:0]  p4_next;
  logic signed [psc_pkg::PRD_W-1:0]  p3_next;
  logic signed [psc_pkg::DT2_W-1:0]  dt2_next;

  // stage 3
  logic                              s3_valid;
  logic [psc_pkg::RAW_W-1:0]         s3_d1;
  logic signed [psc_pkg::DEV_W-1:0]  s3_dev;
  logic signed [psc_pkg::DEV_W-1:0]  s3_c;
  logic [psc_pkg::T2_W-1:0]          s3_t2;
  logic                              s3_low;
  logic                              s3_cold;
  logic signed [psc_pkg::OFF_W-1:0]  s3_off;
  logic signed [psc_pkg::SENS_W-1:0] s3_sens;
  logic signed [psc_pkg::DEV_W-1:0]  dev_next;
  logic [psc_pkg::T2_W-1:0]          t2_base;
  logic [psc_pkg::T2_W-1:0]          t2_low;
  logic [psc_pkg::T2_W-1:0]          t2_high;
  logic [psc_pkg::DT2_W+2:0]         dt2x7;
  logic signed [psc_pkg::OFF_W-1:0]  off_next;
  logic signed [psc_pkg::SENS_W-1:0] sens_next;

  // stage 4
  logic                              s4_valid;
  logic [psc_pkg::RAW_W-1:0]         s4_d1;
  logic [psc_pkg::SQ_W-1:0]          s4_dev2;
  logic [psc_pkg::SQ_W-1:0]          s4_cc;
  logic                              s4_low;
  logic                              s4_cold;
  logic signed [psc_pkg::OFF_W-1:0]  s4_off;
  logic signed [psc_pkg::SENS_W-1:0] s4_sens;
  logic signed [psc_pkg::TEMP_W-1:0] s4_temp;
  logic signed [2*psc_pkg::DEV_W-1:0] dev_sq;
  logic signed [2*psc_pkg::DEV_W-1:0] c_sq;
  logic signed [psc_pkg::TEMP_W-1:0] temp_next;

  // stage 5
  logic [psc_pkg::OFF_W-1:0]         dev2_w;
  logic [psc_pkg::OFF_W-1:0]         cc_w;
  logic [psc_pkg::OFF_W-1:0]         off2;
  logic [psc_pkg::OFF_W-1:0]         sens2;

  assign dt_wide = $signed({2'b0, raw_temperature})
                 - $signed({2'b0, coeff.c5, {psc_pkg::SH_REF{1'b0}}});

  assign p6_next  = s1_dt * $signed({1'b0, coeff.c6});
  assign p4_next  = s1_dt * $signed({1'b0, coeff.c4});
  assign p3_next  = s1_dt * $signed({1'b0, coeff.c3});
  assign dt2_next = s1_dt * s1_dt;

  assign dev_next  = s2_p6[psc_pkg::SH_TEMP+psc_pkg::DEV_W-1:psc_pkg::SH_TEMP];
  assign t2_base   = psc_pkg::T2_W'(s2_dt2[psc_pkg::DT2_W-1:psc_pkg::SH_T2_LO]);
  assign t2_low    = (t2_base << 1) + t2_base;
  assign dt2x7     = ({3'b0, s2_dt2} << 3) - {3'b0, s2_dt2};
  assign t2_high   = psc_pkg::T2_W'(dt2x7[psc_pkg::DT2_W+2:psc_pkg::SH_T2_HI]);
  assign off_next  = $signed(psc_pkg::OFF_W'({coeff.c2, {psc_pkg::SH_C2{1'b0}}}))
                   + psc_pkg::OFF_W'(s2_p4 >>> psc_pkg::SH_OFF);
  assign sens_next = $signed(psc_pkg::SENS_W'({coeff.c1, {psc_pkg::SH_C1{1'b0}}}))
                   + psc_pkg::SENS_W'(s2_p3 >>> psc_pkg::SH_SENS);

  assign dev_sq    = s3_dev * s3_dev;
  assign c_sq      = s3_c * s3_c;
  assign temp_next = psc_pkg::TEMP_W'(s3_dev) + psc_pkg::TEMP_W'(psc_pkg::TEMP_REF)
                   - $signed(psc_pkg::TEMP_W'({1'b0, s3_t2}));

  assign dev2_w = psc_pkg::OFF_W'(s4_dev2);
  assign cc_w   = psc_pkg::OFF_W'(s4_cc);

  always_comb begin
    if (s4_low) begin
      off2  = (((dev2_w << 1) + dev2_w) >> 1) + (s4_cold ? ((cc_w << 3) - cc_w) : '0);
      sens2 = (((dev2_w << 2) + dev2_w) >> 3) + (s4_cold ? (cc_w << 2) : '0);
    end else begin
      off2  = dev2_w >> 4;
      sens2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      mid_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      mid_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1    <= raw_pressure;
      s1_dt    <= dt_wide[psc_pkg::DT_W-1:0];

      s2_d1    <= s1_d1;
      s2_p6    <= p6_next;
      s2_p4    <= p4_next;
      s2_p3    <= p3_next;
      s2_dt2   <= dt2_next;

      s3_d1    <= s2_d1;
      s3_dev   <= dev_next;
      s3_c     <= psc_pkg::DEV_W'(dev_next - psc_pkg::COLD_DEV);
      s3_low   <= dev_next[psc_pkg::DEV_W-1];
      s3_cold  <= dev_next < psc_pkg::COLD_DEV;
      s3_t2    <= dev_next[psc_pkg::DEV_W-1] ? t2_low : t2_high;
      s3_off   <= off_next;
      s3_sens  <= sens_next;

      s4_d1    <= s3_d1;
      s4_dev2  <= dev_sq[psc_pkg::SQ_W-1:0];
      s4_cc    <= c_sq[psc_pkg::SQ_W-1:0];
      s4_low   <= s3_low;
      s4_cold  <= s3_cold;
      s4_off   <= s3_off;
      s4_sens  <= s3_sens;
      s4_temp  <= temp_next;

      mid.d1   <= s4_d1;
      mid.temp <= s4_temp;
      mid.off  <= s4_off - $signed(off2);
      mid.sens <= s4_sens - $signed(psc_pkg::SENS_W'(sens2));
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (en && in_valid) |=> s1_valid)
    else $error("accepted word did not enter stage one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({s1_valid, s2_valid, s3_valid, s4_valid, mid_valid}))
    else $error("front valid bits moved while stalled");

  a_region: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (!s3_cold || s3_low))
    else $error("cold region flagged outside low region");

endmodule

### src/psc_back.sv
// psc_back: stages six to nine, split pressure product, scaling and saturated output registers
// depends on psc_pkg; takes mid_t words from psc_front
module psc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             mid_valid,
  input  psc_pkg::mid_t                    mid,
  output logic                             out_valid,
  output logic signed [psc_pkg::OUT_W-1:0] temperature_centi,
  output logic signed [psc_pkg::OUT_W-1:0] pressure_deci_mbar
);

  logic                               s6_valid;
  logic [psc_pkg::PPL_W-1:0]          s6_pp_lo;
  logic signed [psc_pkg::PPH_W-1:0]   s6_pp_hi;
  logic signed [psc_pkg::TEMP_W-1:0]  s6_temp;
  logic signed [psc_pkg::OFF_W-1:0]   s6_off;
  logic [psc_pkg::PPL_W-1:0]          pp_lo_next;
  logic signed [psc_pkg::PPH_W-1:0]   pp_hi_next;

  logic                               s7_valid;
  logic signed [psc_pkg::PROD_W-1:0]  s7_prod;
  logic signed [psc_pkg::TEMP_W-1:0]  s7_temp;
  logic signed [psc_pkg::OFF_W-1:0]   s7_off;
  logic signed [psc_pkg::PROD_W-1:0]  prod_next;

  logic                               s8_valid;
  logic signed [psc_pkg::R_W-1:0]     s8_r;
  logic signed [psc_pkg::TEMP_W-1:0]  s8_temp;
  logic [psc_pkg::PROD_W-1:0]         prod_bias;
  logic [psc_pkg::PROD_W-1:0]         prod_biased;
  logic signed [psc_pkg::Q_W-1:0]     q;

  logic [psc_pkg::R_W-1:0]            r_bias;
  logic [psc_pkg::R_W-1:0]            r_biased;
  logic signed [psc_pkg::PRES_W-1:0]  pres;

  assign pp_lo_next = mid.sens[psc_pkg::SPLIT-1:0] * mid.d1;
  assign pp_hi_next = $signed(mid.sens[psc_pkg::SENS_W-1:psc_pkg::SPLIT])
                    * $signed({1'b0, mid.d1});

  assign prod_next = (psc_pkg::PROD_W'(s6_pp_hi) << psc_pkg::SPLIT)
                   + psc_pkg::PROD_W'(s6_pp_lo);

  // division toward zero: bias negative values before the shift
  assign prod_bias   = s7_prod[psc_pkg::PROD_W-1]
                     ? psc_pkg::PROD_W'((64'd1 << psc_pkg::SH_P1) - 64'd1) : '0;
  assign prod_biased = s7_prod + prod_bias;
  assign q           = prod_biased[psc_pkg::PROD_W-1:psc_pkg::SH_P1];

  assign r_bias   = s8_r[psc_pkg::R_W-1]
                  ? psc_pkg::R_W'((64'd1 << psc_pkg::SH_P2) - 64'd1) : '0;
  assign r_biased = s8_r + r_bias;
  assign pres     = r_biased[psc_pkg::R_W-1:psc_pkg::SH_P2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s6_valid  <= mid_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      out_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pp_lo <= pp_lo_next;
      s6_pp_hi <= pp_hi_next;
      s6_temp  <= mid.temp;
      s6_off   <= mid.off;

      s7_prod  <= prod_next;
      s7_temp  <= s6_temp;
      s7_off   <= s6_off;

      s8_r     <= psc_pkg::R_W'(q) - psc_pkg::R_W'(s7_off);
      s8_temp  <= s7_temp;

      temperature_centi  <= psc_pkg::sat_word(psc_pkg::SAT_W'(s8_temp));
      pressure_deci_mbar <= psc_pkg::sat_word(psc_pkg::SAT_W'(pres));
    end
  end

  a_travel: assert property (@(posedge clk) disable iff (rst)
    (en && s8_valid) |=> out_valid)
    else $error("word lost before the output register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({s6_valid, s7_valid, s8_valid}))
    else $error("back valid bits moved while stalled");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temperature_centi[psc_pkg::OUT_W-1:psc_pkg::TEMP_W-1] == '0
                   || temperature_centi[psc_pkg::OUT_W-1:psc_pkg::TEMP_W-1] == '1))
    else $error("temperature outside its datapath width");

endmodule

### src/pressure_sensor_compensation.sv
// pressure_sensor_compensation: top level, joins the calibration registers and the two halves
// of the compensation pipeline; depends on psc_pkg, psc_cfg, psc_front and psc_back
//
// Nine-stage pipeline: a raw pressure/temperature word pair accepted on the input appears as
// one compensated word, and a new pair can be accepted on every cycle while in_stall is low.
// The nine register stages hold, in order: offset subtract, three parallel 25x17
// multipliers beside a 25x25 square, first order sums, two 18-bit squares, second order
// corrections, a 39x24 product split into two partial products, their sum, and two truncating
// scale steps. The pipeline advances as one unit: when the output word is held by out_stall,
// in_stall rises in the same cycle and every stage keeps its contents. Calibration words are
// written through the cfg channel, which is always ready, and must only change while no word
// is in flight.
module pressure_sensor_compensation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psc_pkg::COEFF_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [psc_pkg::RAW_W-1:0]        raw_pressure,
  input  logic [psc_pkg::RAW_W-1:0]        raw_temperature,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [psc_pkg::OUT_W-1:0] temperature_centi,
  output logic signed [psc_pkg::OUT_W-1:0] pressure_deci_mbar
);

  psc_pkg::coeff_t coeff;
  psc_pkg::mid_t   mid;
  logic            mid_valid;
  logic            en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  psc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  psc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_valid),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .coeff           (coeff),
    .mid_valid       (mid_valid),
    .mid             (mid)
  );

  psc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .mid_valid          (mid_valid),
    .mid                (mid),
    .out_valid          (out_valid),
    .temperature_centi  (temperature_centi),
    .pressure_deci_mbar (pressure_deci_mbar)
  );

endmodule

### verif/tb_pressure_sensor_compensation.sv
// tb_pressure_sensor_compensation: self-checking testbench for the pressure sensor compensation
// pipeline, with directed and random reading pairs checked against an in-bench predictor
// depends on psc_pkg and pressure_sensor_compensation
module tb_pressure_sensor_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 9;
  localparam logic [psc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [psc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam longint REF_CENTI = 2000;
  localparam longint COLD_CENTI = -1500;
  localparam longint MAX_OUT = 64'sd2147483647;
  localparam longint MIN_OUT = -64'sd2147483648;
  localparam logic [psc_pkg::RAW_W-1:0] RAW_MAX = {psc_pkg::RAW_W{1'b1}};

  typedef struct packed {
    logic signed [psc_pkg::OUT_W-1:0] temp;
    logic signed [psc_pkg::OUT_W-1:0] pres;
  } reading_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [psc_pkg::COEFF_W-1:0]      cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [psc_pkg::RAW_W-1:0]        raw_pressure;
  logic [psc_pkg::RAW_W-1:0]        raw_temperature;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [psc_pkg::OUT_W-1:0] temperature_centi;
  logic signed [psc_pkg::OUT_W-1:0] pressure_deci_mbar;

  psc_pkg::coeff_t cal;
  reading_t        expected_readings[$];
  int              mismatches = 0;
  int              words_checked = 0;
  int              cal_sets = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  int              hold_req = 0;
  int              hold_left = 0;

  pressure_sensor_compensation uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_pressure(raw_pressure),
    .raw_temperature(raw_temperature),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .temperature_centi(temperature_centi),
    .pressure_deci_mbar(pressure_deci_mbar)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [psc_pkg::OUT_W-1:0] clamp_out(input longint v);
    if (v > MAX_OUT) begin
      return MAX_OUT[psc_pkg::OUT_W-1:0];
    end else if (v < MIN_OUT) begin
      return MIN_OUT[psc_pkg::OUT_W-1:0];
    end
    return v[psc_pkg::OUT_W-1:0];
  endfunction

  function automatic reading_t compensate(input logic [psc_pkg::RAW_W-1:0] d1_raw,
                                          input logic [psc_pkg::RAW_W-1:0] d2_raw,
                                          input psc_pkg::coeff_t c);
    longint d1, d2, k1, k2, k3, k4, k5, k6;
    longint dt, temp, dev, dev2, dt2, t2, off2, sens2, off, sens, pres, cold;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    k1 = c.c1;
    k2 = c.c2;
    k3 = c.c3;
    k4 = c.c4;
    k5 = c.c5;
    k6 = c.c6;
    dt = d2 - (k5 << 8);
    temp = ((dt * k6) >>> 23) + REF_CENTI;
    dev = temp - REF_CENTI;
    dev2 = dev * dev;
    dt2 = dt * dt;
    if (temp < REF_CENTI) begin
      t2 = 3 * (dt2 >>> 33);
      off2 = (3 * dev2) / 2;
      sens2 = (5 * dev2) / 8;
      if (temp < COLD_CENTI) begin
        cold = temp - COLD_CENTI;
        off2 = off2 + 7 * (cold * cold);
        sens2 = sens2 + 4 * (cold * cold);
      end
    end else begin
      t2 = (7 * dt2) >>> 37;
      off2 = dev2 / 16;
      sens2 = 0;
    end
    off = (k2 << 16) + ((k4 * dt) >>> 7);
    sens = (k1 << 15) + ((k3 * dt) >>> 8);
    temp = temp - t2;
    off = off - off2;
    sens = sens - sens2;
    pres = ((sens * d1) / 64'sd2097152 - off) / 64'sd32768;
    r.temp = clamp_out(temp);
    r.pres = clamp_out(pres);
    return r;
  endfunction

  function automatic logic [psc_pkg::COEFF_W-1:0] rand_coeff();
    case ($urandom_range(7))
      0: begin
        return '0;
      end
      1: begin
        return {psc_pkg::COEFF_W{1'b1}};
      end
      default: begin
        return psc_pkg::COEFF_W'($urandom);
      end
    endcase
  endfunction

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("out_valid: unexpected word, none pending");
        mismatches++;
      end else begin
        exp_r = expected_readings.pop_front();
        words_checked++;
        if (temperature_centi !== exp_r.temp) begin
          $error("temperature_centi: expected %0d, got %0d", exp_r.temp, temperature_centi);
          mismatches++;
        end
        if (pressure_deci_mbar !== exp_r.pres) begin
          $error("pressure_deci_mbar: expected %0d, got %0d", exp_r.pres, pressure_deci_mbar);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pair(input logic [psc_pkg::RAW_W-1:0] d1,
                           input logic [psc_pkg::RAW_W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_pressure <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(compensate(d1, d2, cal));
    @(negedge clk);
  endtask

  task automatic write_coeff(input logic [psc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psc_pkg::COEFF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psc_pkg::REG_SENS: begin
        cal.c1 = data;
      end
      psc_pkg::REG_OFFSET: begin
        cal.c2 = data;
      end
      psc_pkg::REG_SENS_TC: begin
        cal.c3 = data;
      end
      psc_pkg::REG_OFFSET_TC: begin
        cal.c4 = data;
      end
      psc_pkg::REG_TEMP_REF: begin
        cal.c5 = data;
      end
      psc_pkg::REG_TEMP_SLOPE: begin
        cal.c6 = data;
      end
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic load_cal(input psc_pkg::coeff_t c);
    settle();
    write_coeff(psc_pkg::REG_SENS, c.c1);
    write_coeff(psc_pkg::REG_OFFSET, c.c2);
    write_coeff(psc_pkg::REG_SENS_TC, c.c3);
    write_coeff(psc_pkg::REG_OFFSET_TC, c.c4);
    write_coeff(psc_pkg::REG_TEMP_REF, c.c5);
    write_coeff(psc_pkg::REG_TEMP_SLOPE, c.c6);
    cfg_valid <= 1'b0;
    cal_sets++;
  endtask

  task automatic test_reset_defaults();
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(24'h5A5A5A, 24'hA5A5A5);
  endtask

  task automatic test_typical_cal();
    load_cal('{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
               c5: 16'd33464, c6: 16'd28312});
    send_pair(24'd9085466, 24'd8569150);
    send_pair(24'd9085466, '0);
    send_pair(24'd9085466, RAW_MAX);
    send_pair('0, 24'd8569150);
    send_pair(RAW_MAX, 24'd7000000);
  endtask

  // slope of 2^15 makes the first order temperature step once per 256 counts
  task automatic test_region_edges();
    load_cal('{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
               c5: 16'd33464, c6: 16'd32768});
    send_pair(24'd9085466, 24'd8566784);
    send_pair(24'd9085466, 24'd8566783);
    send_pair(24'd9085466, 24'd7670784);
    send_pair(24'd9085466, 24'd7670783);
  endtask

  task automatic test_spare_index();
    settle();
    write_coeff(REG_SPARE_6, 16'hFFFF);
    write_coeff(REG_SPARE_7, 16'h0000);
    cfg_valid <= 1'b0;
    send_pair(24'd9085466, 24'd8569150);
    send_pair(RAW_MAX, 24'd1234567);
  endtask

  task automatic test_full_scale_cal();
    load_cal('{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF, c4: 16'hFFFF,
               c5: 16'hFFFF, c6: 16'hFFFF});
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
  endtask

  task automatic test_random_traffic();
    int idle_mix[4] = '{0, 59, 0, 21};
    int stall_mix[4] = '{0, 0, 59, 21};
    psc_pkg::coeff_t c;
    logic [psc_pkg::RAW_W-1:0] d1;
    logic [psc_pkg::RAW_W-1:0] d2;
    for (int ph = 0; ph < 8; ph++) begin
      c.c1 = rand_coeff();
      c.c2 = rand_coeff();
      c.c3 = rand_coeff();
      c.c4 = rand_coeff();
      c.c5 = rand_coeff();
      c.c6 = rand_coeff();
      load_cal(c);
      send_idle_pct = idle_mix[ph % 4];
      stall_pct = stall_mix[ph % 4];
      for (int n = 0; n < 122; n++) begin
        case ($urandom_range(9))
          0: begin
            d1 = '0;
          end
          1: begin
            d1 = RAW_MAX;
          end
          default: begin
            d1 = psc_pkg::RAW_W'($urandom);
          end
        endcase
        // near the reference temperature the region switches are dense
        if ($urandom_range(2) == 0) begin
          d2 = psc_pkg::RAW_W'({cal.c5, 8'h00} + $urandom_range(65535) - 32768);
        end else begin
          d2 = psc_pkg::RAW_W'($urandom);
        end
        send_pair(d1, d2);
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    load_cal('{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
               c5: 16'd33464, c6: 16'd28312});
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 120;
    for (int n = 0; n < 40; n++) begin
      send_pair(psc_pkg::RAW_W'($urandom), psc_pkg::RAW_W'($urandom));
    end
    stall_pct = 30;
    for (int n = 0; n < 20; n++) begin
      send_pair(psc_pkg::RAW_W'($urandom), psc_pkg::RAW_W'($urandom));
    end
    stall_pct = 0;
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    cal = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_typical_cal();
    test_region_edges();
    test_spare_index();
    test_full_scale_cal();
    test_random_traffic();
    test_backpressure();
    settle();
    $display("checked %0d compensated words under %0d calibration sets plus reset defaults,",
             words_checked, cal_sets);
    $display("across all temperature regions, idle and stall mixes and a long output hold-off");
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
